FILE: rtl/core/irc_pkg.sv
`timescale 1ns / 1ps

package irc_pkg;

  // Line length limit; offsets live in 10-bit fields, so the limit is clamped to 1023.
  localparam int MAX_LEN   = 512;
  localparam int PARAM_MAX = 15;
  localparam int POS_W     = 10;
  localparam logic [POS_W-1:0] POS_LIMIT = (MAX_LEN > 1023) ? 10'd1023 : POS_W'(MAX_LEN);

  // Token kinds
  localparam logic [2:0] TK_PREFIX   = 3'd0;
  localparam logic [2:0] TK_COMMAND  = 3'd1;
  localparam logic [2:0] TK_MIDDLE   = 3'd2;
  localparam logic [2:0] TK_TRAILING = 3'd3;
  localparam logic [2:0] TK_END      = 3'd4;
  localparam logic [2:0] TK_ERROR    = 3'd5;

  // Command keywords
  localparam int NKEYS = 10;
  localparam logic [3:0] CMD_UNKNOWN = 4'd10;

  localparam logic [3:0] KEY_LEN [NKEYS] = '{
    4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd6, 4'd4, 4'd7
  };

  localparam logic [7:0] KEY_CHARS [NKEYS][8] = '{
    '{"C", "A", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"N", "I", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"U", "S", "E", "R", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "A", "S", "S", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"J", "O", "I", "N", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"T", "O", "P", "I", "C", 8'h00, 8'h00, 8'h00},
    '{"M", "O", "D", "E", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"I", "N", "V", "I", "T", "E", 8'h00, 8'h00},
    '{"K", "I", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "R", "I", "V", "M", "S", "G", 8'h00}
  };

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Queue between parser and output stage
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One byte's worth of results: an optional token, then an optional end/error.
  typedef struct packed {
    logic             has_t;
    logic [2:0]       t_kind;
    logic [POS_W-1:0] t_start;
    logic [POS_W-1:0] t_end;
    logic             has_z;
    logic             z_err;
    logic [POS_W-1:0] pos;
    logic [3:0]       cmd;
    logic [3:0]       params;
    logic             trail;
  } irc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } irc_qstat_t;

endpackage

FILE: rtl/core/irc_message_line_parser_top.sv
`timescale 1ns / 1ps

// IRC line parser: feed one byte of the received buffer per request, with
// in_buffer_end on the last one. The block splits each line into prefix,
// command, middle params and trailing, reporting start/end offsets, a
// command code from a case-sensitive match of ten keywords, a running param
// count, and a message end or error request; each input byte yields zero,
// one or two results, run_last marking the final one. A byte is taken every
// cycle: the parser does its phase update and keyword compare in the cycle
// the byte arrives, and results go through a four-entry queue to a
// registered output stage that sends one result per cycle while out_stall is
// low. A byte with two results is sent as two results in turn; input stalls
// only when the queue is full. The parser returns to start of line after
// the buffer's last byte.

module irc_message_line_parser_top
  import irc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // byte requests
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_buffer_end,
  // token requests
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_token_kind,
  output logic [POS_W-1:0] out_token_start,
  output logic [POS_W-1:0] out_token_end,
  output logic [3:0]       out_command_code,
  output logic [3:0]       out_param_count,
  output logic             out_has_trailing,
  output logic             out_run_last
);

  irc_entry_t push_entry, head;
  irc_qstat_t q_stat;
  logic       push, pop;

  // front stalls only on a full queue
  assign in_stall = q_stat.full;

  // parser: phase tracking, offsets, keyword match
  irc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data_byte  (in_data_byte),
    .in_buffer_end (in_buffer_end),
    .q_stat        (q_stat),
    .push          (push),
    .push_entry    (push_entry)
  );

  // per-byte result pairs
  irc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // output stage: splits a pair into single results
  irc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_stat           (q_stat),
    .pop              (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_end    (out_token_end),
    .out_command_code (out_command_code),
    .out_param_count  (out_param_count),
    .out_has_trailing (out_has_trailing),
    .out_run_last     (out_run_last)
  );

  // end/error always closes a byte's results and sits at one offset
  a_term_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == TK_END || out_token_kind == TK_ERROR)
    |-> out_run_last && (out_token_start == out_token_end))
    else $error("end/error result not last or has nonzero span");

  // a token that is not last must be followed by end/error of the same byte
  a_not_last_token : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> out_token_kind != TK_END && out_token_kind != TK_ERROR)
    else $error("non-last result is a terminator");

  // trailing counts as a parameter
  a_trail_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_trailing |-> out_param_count != 4'd0)
    else $error("trailing flagged with zero param count");

  a_trail_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == TK_TRAILING |-> out_has_trailing)
    else $error("trailing token without has_trailing");

endmodule

FILE: rtl/core/irc_front.sv
`timescale 1ns / 1ps

module irc_front
  import irc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data_byte,
  input  logic       in_buffer_end,
  input  irc_qstat_t q_stat,
  output logic       push,
  output irc_entry_t push_entry
);

  localparam logic [3:0] PH_START       = 4'd0;
  localparam logic [3:0] PH_PREFIX      = 4'd1;
  localparam logic [3:0] PH_SKIP_PREFIX = 4'd2;
  localparam logic [3:0] PH_COMMAND     = 4'd3;
  localparam logic [3:0] PH_SKIP_MID    = 4'd4;
  localparam logic [3:0] PH_MIDDLE      = 4'd5;
  localparam logic [3:0] PH_TRAILING    = 4'd6;
  localparam logic [3:0] PH_LF          = 4'd7;
  localparam logic [3:0] PH_IDLE        = 4'd8;

  logic [3:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, start_r, start_nxt;
  logic [NKEYS-1:0] match_r, match_nxt;
  logic [3:0]       cmd_r, cmd_nxt;
  logic [3:0]       params_r, params_nxt;
  logic             trail_r, trail_nxt;

  logic             acc;
  logic             is_cr, is_sp, is_colon, is_lf, last;
  logic [POS_W-1:0] pos1, cstart, off, len_f;
  logic [NKEYS-1:0] kill, match_f;
  logic [3:0]       found;
  logic             cmd_path, cmd_term, count;
  logic             t_v, z_v, z_err;
  logic [2:0]       t_kind;
  logic [POS_W-1:0] t_s, t_e;

  assign acc      = in_valid & ~q_stat.full;
  assign last     = in_buffer_end;
  assign is_cr    = (in_data_byte == CH_CR);
  assign is_sp    = (in_data_byte == CH_SPACE);
  assign is_colon = (in_data_byte == CH_COLON);
  assign is_lf    = (in_data_byte == CH_LF);
  assign pos1     = pos_r + 10'd1;

  // Keyword tracking for the command word; start is this byte when the word begins here
  assign cstart   = (phase_r == PH_COMMAND) ? start_r : pos_r;
  assign off      = pos_r - cstart;
  assign cmd_term = is_cr | is_sp;
  assign len_f    = cmd_term ? off : off + 10'd1;

  always_comb begin
    for (int k = 0; k < NKEYS; k++) begin
      kill[k] = (off >= {6'd0, KEY_LEN[k]}) || (KEY_CHARS[k][off[2:0]] != in_data_byte);
    end
    match_f = cmd_term ? match_r : (match_r & ~kill);
    found = CMD_UNKNOWN;
    for (int k = 0; k < NKEYS; k++) begin
      if (match_f[k] && (len_f == {6'd0, KEY_LEN[k]})) found = 4'(k);
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    start_nxt  = start_r;
    match_nxt  = match_r;
    cmd_nxt    = cmd_r;
    trail_nxt  = trail_r;
    cmd_path   = 1'b0;
    count      = 1'b0;
    t_v        = 1'b0;
    t_kind     = TK_PREFIX;
    t_s        = start_r;
    t_e        = pos_r;
    z_v        = 1'b0;
    z_err      = 1'b0;

    if (phase_r == PH_IDLE) begin
      // ignored until buffer end
    end else if (pos_r >= POS_LIMIT) begin
      z_v       = 1'b1;
      z_err     = 1'b1;
      phase_nxt = PH_IDLE;
    end else begin
      unique case (phase_r)
        PH_START: begin
          if (is_colon) begin
            phase_nxt = PH_PREFIX;
            start_nxt = pos1;
          end else begin
            cmd_path = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (is_sp) begin
            t_v       = 1'b1;
            t_kind    = TK_PREFIX;
            phase_nxt = PH_SKIP_PREFIX;
          end
        end
        PH_SKIP_PREFIX: begin
          if (!is_sp) cmd_path = 1'b1;
        end
        PH_COMMAND: begin
          cmd_path = 1'b1;
        end
        PH_SKIP_MID: begin
          if (is_colon) begin
            phase_nxt = PH_TRAILING;
            start_nxt = pos1;
          end else if (is_cr) begin
            // space then CR: empty middle param
            t_v       = 1'b1;
            t_kind    = TK_MIDDLE;
            t_s       = pos_r;
            count     = 1'b1;
            phase_nxt = PH_LF;
          end else if (!is_sp) begin
            start_nxt = pos_r;
            phase_nxt = PH_MIDDLE;
          end
        end
        PH_MIDDLE: begin
          if (is_sp || is_cr) begin
            t_v       = 1'b1;
            t_kind    = TK_MIDDLE;
            count     = 1'b1;
            phase_nxt = is_cr ? PH_LF : PH_SKIP_MID;
          end
        end
        PH_TRAILING: begin
          if (is_cr) begin
            if (pos_r > start_r) begin
              t_v       = 1'b1;
              t_kind    = TK_TRAILING;
              count     = 1'b1;
              trail_nxt = 1'b1;
            end
            phase_nxt = PH_LF;
          end
        end
        PH_LF: begin
          z_v       = 1'b1;
          z_err     = ~is_lf;
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      if (cmd_path) begin
        start_nxt = cstart;
        t_s       = cstart;
        if (cmd_term) begin
          t_v       = 1'b1;
          t_kind    = TK_COMMAND;
          t_e       = pos_r;
          phase_nxt = is_cr ? PH_LF : PH_SKIP_MID;
        end else begin
          phase_nxt = PH_COMMAND;
          if (last) begin
            t_v    = 1'b1;
            t_kind = TK_COMMAND;
            t_e    = pos1;
          end
        end
        if (cmd_term || last) begin
          cmd_nxt   = found;
          match_nxt = (found < CMD_UNKNOWN) ? (NKEYS'(1) << found) : '0;
        end else begin
          match_nxt = match_f;
        end
      end

      // CR as the buffer's last byte is an error
      if (phase_nxt == PH_LF && last) begin
        phase_nxt = PH_IDLE;
        z_v       = 1'b1;
        z_err     = 1'b1;
      end

      // buffer ends mid-line: close the open token, then message end
      if (last && phase_nxt != PH_IDLE && phase_nxt != PH_LF) begin
        z_v = 1'b1;
        if (phase_nxt == PH_PREFIX) begin
          t_v    = 1'b1;
          t_kind = TK_PREFIX;
          t_s    = start_nxt;
          t_e    = pos1;
        end else if (phase_nxt == PH_MIDDLE) begin
          t_v    = 1'b1;
          t_kind = TK_MIDDLE;
          t_s    = start_nxt;
          t_e    = pos1;
          count  = 1'b1;
        end else if (phase_nxt == PH_TRAILING && pos1 > start_nxt) begin
          t_v       = 1'b1;
          t_kind    = TK_TRAILING;
          t_s       = start_nxt;
          t_e       = pos1;
          count     = 1'b1;
          trail_nxt = 1'b1;
        end
      end
    end

    params_nxt = (count && params_r < 4'(PARAM_MAX)) ? params_r + 4'd1 : params_r;
  end

  assign push = acc & (t_v | z_v);

  always_comb begin
    push_entry.has_t   = t_v;
    push_entry.t_kind  = t_kind;
    push_entry.t_start = t_s;
    push_entry.t_end   = t_e;
    push_entry.has_z   = z_v;
    push_entry.z_err   = z_err;
    push_entry.pos     = pos_r;
    push_entry.cmd     = cmd_nxt;
    push_entry.params  = params_nxt;
    push_entry.trail   = trail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last)) begin
      phase_r  <= PH_START;
      pos_r    <= '0;
      start_r  <= '0;
      match_r  <= '1;
      cmd_r    <= CMD_UNKNOWN;
      params_r <= '0;
      trail_r  <= 1'b0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      start_r  <= start_nxt;
      match_r  <= match_nxt;
      cmd_r    <= cmd_nxt;
      params_r <= params_nxt;
      trail_r  <= trail_nxt;
      if (pos_r < POS_LIMIT) pos_r <= pos1;
    end
  end

endmodule

FILE: rtl/core/irc_fifo.sv
`timescale 1ns / 1ps

module irc_fifo
  import irc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  irc_entry_t push_entry,
  input  logic       pop,
  output irc_entry_t head,
  output irc_qstat_t q_stat
);

  irc_entry_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head         = mem[rd_ptr_r];
  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + QCNT_W'(1);
      else if (!push && pop) count_r <= count_r - QCNT_W'(1);
    end
  end

endmodule

FILE: rtl/core/irc_back.sv
`timescale 1ns / 1ps

module irc_back
  import irc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  irc_entry_t       head,
  input  irc_qstat_t       q_stat,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [2:0]       out_token_kind,
  output logic [POS_W-1:0] out_token_start,
  output logic [POS_W-1:0] out_token_end,
  output logic [3:0]       out_command_code,
  output logic [3:0]       out_param_count,
  output logic             out_has_trailing,
  output logic             out_run_last
);

  logic             out_valid_r, sel_z_r, sel_z_nxt, load, take_z;
  logic [2:0]       kind_r, kind_nxt;
  logic [POS_W-1:0] start_r, start_nxt, end_r, end_nxt;
  logic [3:0]       cmd_r, params_r;
  logic             trail_r, last_r, last_nxt;

  assign load   = ~q_stat.empty & (~out_valid_r | ~out_stall);
  assign take_z = ~head.has_t | sel_z_r;

  always_comb begin
    if (!take_z) begin
      kind_nxt  = head.t_kind;
      start_nxt = head.t_start;
      end_nxt   = head.t_end;
      last_nxt  = ~head.has_z;
      sel_z_nxt = head.has_z;
    end else begin
      kind_nxt  = head.z_err ? TK_ERROR : TK_END;
      start_nxt = head.pos;
      end_nxt   = head.pos;
      last_nxt  = 1'b1;
      sel_z_nxt = 1'b0;
    end
  end

  // entry leaves the queue once its final result is loaded
  assign pop = load & ~sel_z_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_z_r     <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      sel_z_r     <= sel_z_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= kind_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      cmd_r    <= head.cmd;
      params_r <= head.params;
      trail_r  <= head.trail;
      last_r   <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_kind   = kind_r;
  assign out_token_start  = start_r;
  assign out_token_end    = end_r;
  assign out_command_code = cmd_r;
  assign out_param_count  = params_r;
  assign out_has_trailing = trail_r;
  assign out_run_last     = last_r;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the IRC message line parser.
// Byte requests go in one per handshake; the token predictor below tracks
// the line state and queues the tokens each byte should produce. Every
// token request that comes out is checked field by field against the
// oldest queued token.

module tb_top;
  import irc_pkg::*;

  // ---------------------------------------------------------------------------
  // DUT connections
  // ---------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_data_byte = 8'h00;
  logic             in_buffer_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       out_token_kind;
  logic [POS_W-1:0] out_token_start;
  logic [POS_W-1:0] out_token_end;
  logic [3:0]       out_command_code;
  logic [3:0]       out_param_count;
  logic             out_has_trailing;
  logic             out_run_last;

  irc_message_line_parser_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_buffer_end    (in_buffer_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_end    (out_token_end),
    .out_command_code (out_command_code),
    .out_param_count  (out_param_count),
    .out_has_trailing (out_has_trailing),
    .out_run_last     (out_run_last)
  );

  // 20 ns period
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Expected tokens
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [2:0]       kind;
    logic [POS_W-1:0] t_start;
    logic [POS_W-1:0] t_end;
    logic [3:0]       cmd;
    logic [3:0]       params;
    logic             trail;
    logic             run_last;
  } tok_t;

  tok_t exp_tokens[$];
  int   errors = 0;

  // ---------------------------------------------------------------------------
  // Token predictor: line state
  // ---------------------------------------------------------------------------
  typedef enum logic [3:0] {
    LN_START, LN_PREFIX, LN_PREFIX_GAP, LN_COMMAND, LN_PARAM_GAP,
    LN_MIDDLE, LN_TRAILING, LN_WAIT_LF, LN_DONE
  } line_phase_e;

  line_phase_e      ln_phase;
  int               cur_pos;
  int               tok_begin;
  logic [NKEYS-1:0] kw_live;
  int               nparams;
  logic             trail_seen;
  logic [3:0]       cmd_res;

  // tokens of the byte being predicted, flagged and queued at the end
  tok_t             byte_toks[2];
  int               n_emit;

  task automatic clear_line_state();
    ln_phase   = LN_START;
    cur_pos    = 0;
    tok_begin  = 0;
    kw_live    = '1;
    nparams    = 0;
    trail_seen = 1'b0;
    cmd_res    = CMD_UNKNOWN;
  endtask

  task automatic post_token(input logic [2:0] kind, input int s, input int e);
    if (n_emit < 2) begin
      byte_toks[n_emit].kind     = kind;
      byte_toks[n_emit].t_start  = s[POS_W-1:0];
      byte_toks[n_emit].t_end    = e[POS_W-1:0];
      byte_toks[n_emit].cmd      = cmd_res;
      byte_toks[n_emit].params   = nparams[3:0];
      byte_toks[n_emit].trail    = trail_seen;
      byte_toks[n_emit].run_last = 1'b0;
      n_emit++;
    end
  endtask

  task automatic bump_params();
    if (nparams < PARAM_MAX) nparams++;
  endtask

  task automatic post_middle(input int s, input int e);
    bump_params();
    post_token(TK_MIDDLE, s, e);
  endtask

  // an empty trailing is dropped and not counted
  task automatic post_trailing(input int s, input int e);
    if (e > s) begin
      trail_seen = 1'b1;
      bump_params();
      post_token(TK_TRAILING, s, e);
    end
  endtask

  task automatic flag_error(input int p);
    ln_phase = LN_DONE;
    post_token(TK_ERROR, p, p);
  endtask

  // resolve the command code from the surviving keywords and the word length
  task automatic close_command(input int e);
    int         len;
    logic [3:0] found;
    len   = e - tok_begin;
    found = CMD_UNKNOWN;
    for (int k = 0; k < NKEYS; k++) begin
      if (kw_live[k] && (KEY_LEN[k] == len)) found = 4'(k);
    end
    cmd_res = found;
    kw_live = (found < NKEYS) ? (NKEYS'(1) << found) : '0;
    post_token(TK_COMMAND, tok_begin, e);
  endtask

  task automatic hit_cr(input int p, input logic is_end);
    if (is_end) flag_error(p);
    else ln_phase = LN_WAIT_LF;
  endtask

  task automatic command_char(input logic [7:0] b, input int p, input logic is_end);
    int off;
    if (b == CH_CR || b == CH_SPACE) begin
      close_command(p);
      if (b == CH_CR) hit_cr(p, is_end);
      else ln_phase = LN_PARAM_GAP;
    end else begin
      off = p - tok_begin;
      for (int k = 0; k < NKEYS; k++) begin
        if (off >= KEY_LEN[k]) kw_live[k] = 1'b0;
        else if (KEY_CHARS[k][off] != b) kw_live[k] = 1'b0;
      end
      ln_phase = LN_COMMAND;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic is_end);
    int p;
    p      = cur_pos;
    n_emit = 0;
    if (ln_phase == LN_DONE) begin
      // ignored up to the buffer's last byte
    end else if (p >= POS_LIMIT) begin
      flag_error(p);
    end else begin
      case (ln_phase)
        LN_START: begin
          if (b == CH_COLON) begin
            ln_phase  = LN_PREFIX;
            tok_begin = p + 1;
          end else begin
            tok_begin = p;
            command_char(b, p, is_end);
          end
        end
        LN_PREFIX: begin
          if (b == CH_SPACE) begin
            post_token(TK_PREFIX, tok_begin, p);
            ln_phase = LN_PREFIX_GAP;
          end
        end
        LN_PREFIX_GAP: begin
          if (b != CH_SPACE) begin
            tok_begin = p;
            command_char(b, p, is_end);
          end
        end
        LN_COMMAND: command_char(b, p, is_end);
        LN_PARAM_GAP: begin
          if (b == CH_COLON) begin
            ln_phase  = LN_TRAILING;
            tok_begin = p + 1;
          end else if (b == CH_CR) begin
            post_middle(p, p);
            hit_cr(p, is_end);
          end else if (b != CH_SPACE) begin
            tok_begin = p;
            ln_phase  = LN_MIDDLE;
          end
        end
        LN_MIDDLE: begin
          if (b == CH_SPACE) begin
            post_middle(tok_begin, p);
            ln_phase = LN_PARAM_GAP;
          end else if (b == CH_CR) begin
            post_middle(tok_begin, p);
            hit_cr(p, is_end);
          end
        end
        LN_TRAILING: begin
          if (b == CH_CR) begin
            post_trailing(tok_begin, p);
            hit_cr(p, is_end);
          end
        end
        LN_WAIT_LF: begin
          if (b == CH_LF) begin
            ln_phase = LN_DONE;
            post_token(TK_END, p, p);
          end else begin
            flag_error(p);
          end
        end
        default: ln_phase = LN_DONE;
      endcase

      // buffer ends mid-line: close the open token, then message end
      if (is_end && ln_phase != LN_DONE && ln_phase != LN_WAIT_LF) begin
        case (ln_phase)
          LN_PREFIX:   post_token(TK_PREFIX, tok_begin, p + 1);
          LN_COMMAND:  close_command(p + 1);
          LN_MIDDLE:   post_middle(tok_begin, p + 1);
          LN_TRAILING: post_trailing(tok_begin, p + 1);
          default: ;
        endcase
        post_token(TK_END, p, p);
      end
    end

    if (n_emit > 0) byte_toks[n_emit-1].run_last = 1'b1;
    for (int i = 0; i < n_emit; i++) exp_tokens.insert(exp_tokens.size(), byte_toks[i]);

    if (is_end) clear_line_state();
    else if (cur_pos < POS_LIMIT) cur_pos++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: byte requests, driven on the falling edge
  // ---------------------------------------------------------------------------
  logic       tx_idle_en = 1'b1;
  logic [7:0] line_q[$];

  // entered and left on a falling edge; valid stays high into the next call
  task automatic send_byte(input logic [7:0] b, input logic is_end);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_buffer_end <= is_end;
    do @(posedge clk); while (in_stall);
    predict_byte(b, is_end);
    @(negedge clk);
  endtask

  // one buffer: last byte carries buffer_end
  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic line_add(input logic [7:0] c);
    line_q.insert(line_q.size(), c);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) line_add(s[i]);
  endtask

  task automatic add_keyword(input int k, input int n);
    for (int i = 0; i < n; i++) line_add(KEY_CHARS[k][i]);
  endtask

  // any byte but the ones that end a middle token
  function automatic logic [7:0] param_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_SPACE || c == CH_CR) c = "x";
    return c;
  endfunction

  task automatic add_word(input int n);
    for (int i = 0; i < n; i++) line_add(param_char());
  endtask

  task automatic add_spaces();
    repeat ($urandom_range(1, 2)) line_add(CH_SPACE);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (exp_tokens.size() != 0) @(negedge clk);
    // let any stray extra token show up
    repeat (20) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall driven on the falling edge, checks at the rising edge
  // ---------------------------------------------------------------------------
  logic rx_idle_en = 1'b1;
  int   rx_accepts = 0;
  int   rx_seen = 0;
  int   rx_wait = 0;
  int   hold_len = 0;
  int   hold_go = 0;
  int   hold_ack = 0;
  int   hold_left = 0;
  tok_t want_tok;

  // long hold-offs are counted down here; otherwise a fresh wait per request
  always @(negedge clk) begin
    if (hold_go != hold_ack) begin
      hold_left = hold_len;
      hold_ack  = hold_go;
    end
    if (rx_accepts != rx_seen) begin
      rx_seen = rx_accepts;
      rx_wait = rx_idle_en ? $urandom_range(0, 9) : 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      rx_accepts++;
      if (exp_tokens.size() == 0) begin
        errors++;
        $display("%0t: unexpected token: expected none, actual kind=%0d start=%0d end=%0d",
                 $time, out_token_kind, out_token_start, out_token_end);
      end else begin
        want_tok = exp_tokens.pop_front();
        if (out_token_kind !== want_tok.kind || out_token_start !== want_tok.t_start ||
            out_token_end !== want_tok.t_end || out_command_code !== want_tok.cmd ||
            out_param_count !== want_tok.params || out_has_trailing !== want_tok.trail ||
            out_run_last !== want_tok.run_last) begin
          errors++;
          $display("%0t: token mismatch expected kind=%0d s=%0d e=%0d cmd=%0d pc=%0d tr=%0d rl=%0d",
                   $time, want_tok.kind, want_tok.t_start, want_tok.t_end, want_tok.cmd,
                   want_tok.params, want_tok.trail, want_tok.run_last);
          $display("%0t:                actual kind=%0d s=%0d e=%0d cmd=%0d pc=%0d tr=%0d rl=%0d",
                   $time, out_token_kind, out_token_start, out_token_end, out_command_code,
                   out_param_count, out_has_trailing, out_run_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // prefix, command, middle, trailing, and the empty-token corner cases
  task automatic test_token_shapes();
    add_str(":p CAP x :y\r\n");
    send_line();
    // colon inside a middle param, then space before CR gives an empty middle
    add_str("KICK a:b \r\n");
    send_line();
    // empty trailing is dropped
    add_str("JOIN :\r\n");
    send_line();
    // empty prefix and empty command
    add_str(": \r\n");
    send_line();
    wait_drain();
  endtask

  // buffer ends inside a token, after a space, after the prefix colon,
  // on a CR, CR without LF, and junk after CR LF
  task automatic test_buffer_end_cases();
    add_str("NICK a");
    send_line();
    add_str("USER ");
    send_line();
    add_str(":");
    send_line();
    add_str("\r");
    send_line();
    add_str("X\rY");
    send_line();
    add_str("PASS\r\n");
    line_add(8'h00);
    line_add(8'hFF);
    send_line();
    wait_drain();
  endtask

  // line around the offset limit: the last legal offset is a plain byte,
  // the limit itself gives an error and the tail is ignored
  task automatic test_line_length_limit();
    add_str("TOPIC ");
    repeat (POS_LIMIT) line_add("c");
    send_line();
    wait_drain();
  endtask

  task automatic test_param_saturation();
    add_str("MODE");
    repeat (17) add_str(" p");
    add_str(" :t\r\n");
    send_line();
    wait_drain();
  endtask

  // receiver holds off while the sender keeps pushing bytes
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_len   = 120;
    hold_go++;
    repeat (3) add_str("MODE a b c d e f g h :end\r\n");
    send_line();
    wait_drain();
    tx_idle_en = 1'b1;
  endtask

  task automatic build_random_line();
    int sel;
    int k;
    int idx;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      // pure noise
      repeat ($urandom_range(1, 12)) line_add(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 2) == 0) begin
      line_add(CH_COLON);
      add_word($urandom_range(0, 6));
      add_spaces();
    end
    // command word: mostly real keywords, some near misses
    k   = $urandom_range(0, NKEYS - 1);
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      add_keyword(k, KEY_LEN[k]);
    end else if (sel == 6) begin
      add_keyword(k, KEY_LEN[k] - 1);
    end else if (sel == 7) begin
      add_keyword(k, KEY_LEN[k]);
      line_add(8'("A" + $urandom_range(0, 25)));
    end else if (sel == 8) begin
      idx = line_q.size() + $urandom_range(0, KEY_LEN[k] - 1);
      add_keyword(k, KEY_LEN[k]);
      line_q[idx] = line_q[idx] | 8'h20;
    end else begin
      repeat ($urandom_range(1, 8)) line_add(8'("A" + $urandom_range(0, 25)));
    end
    // middle params
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 4)) begin
      add_spaces();
      add_word($urandom_range(1, 6));
    end
    if ($urandom_range(0, 1) == 1) begin
      add_spaces();
      line_add(CH_COLON);
      repeat ($urandom_range(0, 8)) begin
        idx = $urandom_range(0, 255);
        line_add((8'(idx) == CH_CR) ? CH_SPACE : 8'(idx));
      end
    end
    // line ending
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      line_add(CH_CR);
      line_add(CH_LF);
      repeat ($urandom_range(0, 3)) line_add(8'($urandom_range(0, 255)));
    end else if (sel == 7) begin
      line_add(CH_SPACE);
    end else if (sel == 8) begin
      line_add(CH_CR);
    end else if (sel == 9) begin
      line_add(CH_CR);
      idx = $urandom_range(0, 255);
      line_add((8'(idx) == CH_LF) ? 8'h00 : 8'(idx));
      repeat ($urandom_range(0, 2)) line_add(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_lines();
    int sent;
    sent = 0;
    while (sent < 300) begin
      build_random_line();
      sent += line_q.size();
      // occasional stretches with no idling on either side
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      send_line();
    end
    wait_drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_line_state();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_token_shapes();
    test_buffer_end_cases();
    test_line_length_limit();
    test_param_saturation();
    test_backpressure();
    test_random_lines();

    wait_drain();
    if (exp_tokens.size() != 0) begin
      errors++;
      $display("%0t: %0d expected tokens never arrived", $time, exp_tokens.size());
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
